FILE: hdl/stcc_pkg.sv
`timescale 1ns / 1ps

package stcc_pkg;

  localparam int NUM_CHANNELS_DEF = 14;
  localparam int INDEX_BITS_DEF   = 16;

  localparam int CHAN_W    = 4;
  localparam int SAMPLE_W  = 16;
  localparam int EID_W     = 32;
  localparam int CNT_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_START   = 3'd0,
    CFG_WINDOW_STOP    = 3'd1,
    CFG_STEP_THRESHOLD = 3'd2,
    CFG_MIN_SEPARATION = 3'd3,
    CFG_TRAIN_MIN      = 3'd4,
    CFG_TRAIN_MAX      = 3'd5,
    CFG_COINC_DISTANCE = 3'd6
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] RST_WINDOW_START   = 16'd0;
  localparam logic [CFG_W-1:0] RST_WINDOW_STOP    = 16'd1000;
  localparam logic [CFG_W-1:0] RST_STEP_THRESHOLD = 16'd25;
  localparam logic [CFG_W-1:0] RST_MIN_SEPARATION = 16'd100;
  localparam logic [CFG_W-1:0] RST_TRAIN_MIN      = 16'd1;
  localparam logic [CFG_W-1:0] RST_TRAIN_MAX      = 16'd100;
  localparam logic [CFG_W-1:0] RST_COINC_DISTANCE = 16'd3;

  typedef struct packed {
    logic [CFG_W-1:0] window_start;
    logic [CFG_W-1:0] window_stop;
    logic [CFG_W-1:0] step_threshold;
    logic [CFG_W-1:0] min_separation;
    logic [CFG_W-1:0] train_min;
    logic [CFG_W-1:0] train_max;
    logic [CFG_W-1:0] coinc_distance;
  } cfg_t;

  // Per-channel record held in the channel memory.
  typedef struct packed {
    logic [CNT_W-1:0] events_since;
    logic [CNT_W-1:0] coinc_total;
    logic [EID_W-1:0] first_id;
    logic [EID_W-1:0] last_id;
  } chan_rec_t;

  localparam int REC_W = $bits(chan_rec_t);

  // End of one waveform, handed from the sample front end to the channel stage.
  typedef struct packed {
    logic              valid;
    logic [CHAN_W-1:0] ch;
    logic [CNT_W-1:0]  count;
    logic [EID_W-1:0]  eid;
  } wave_end_t;

  typedef struct packed {
    logic [CHAN_W-1:0] ch;
    logic [CNT_W-1:0]  spike_count;
    logic              train_found;
    logic              coinc_found;
    logic [CNT_W-1:0]  coinc_total;
    logic [EID_W-1:0]  first_id;
    logic [EID_W-1:0]  last_id;
  } result_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

FILE: hdl/stcc_ram.sv
`timescale 1ns / 1ps

module stcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/stcc_wave.sv
`timescale 1ns / 1ps

module stcc_wave #(
  parameter int NUM_CHANNELS = 14,
  parameter int INDEX_BITS   = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  stcc_pkg::cfg_t                        cfg,
  input  logic                                  fire,
  input  logic [stcc_pkg::CHAN_W-1:0]           channel,
  input  logic signed [stcc_pkg::SAMPLE_W-1:0]  sample,
  input  logic [INDEX_BITS-1:0]                 sample_index,
  input  logic                                  last_sample,
  input  logic [stcc_pkg::EID_W-1:0]            evt_id,
  output stcc_pkg::wave_end_t                   wave_end
);

  import stcc_pkg::*;

  localparam int SEP_W = (INDEX_BITS > CFG_W) ? INDEX_BITS : CFG_W;

  logic signed [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic [INDEX_BITS-1:0]      last_hit_r, last_hit_nxt;
  logic                       hit_valid_r, hit_valid_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;

  logic                       in_range;
  logic                       in_win;
  logic [INDEX_BITS-1:0]      wstart;
  logic [INDEX_BITS-1:0]      wstop;
  logic [INDEX_BITS-1:0]      base;
  logic signed [SAMPLE_W+1:0] step_s;
  logic signed [SAMPLE_W+1:0] thr_s;
  logic                       step_hit;
  logic                       sep_ok;
  logic                       hit;
  logic [CNT_W-1:0]           count_new;

  always_comb begin
    in_range  = int'(channel) < NUM_CHANNELS;
    wstart    = INDEX_BITS'(cfg.window_start);
    wstop     = INDEX_BITS'(cfg.window_stop);
    in_win    = (sample_index > wstart) && (sample_index <= wstop);
    step_s    = {{2{sample[SAMPLE_W-1]}}, sample} - {{2{prev_r[SAMPLE_W-1]}}, prev_r};
    thr_s     = {2'b00, cfg.step_threshold};
    step_hit  = step_s > thr_s;
    base      = hit_valid_r ? last_hit_r : wstart;
    sep_ok    = (sample_index >= base) &&
                (SEP_W'(sample_index - base) >= SEP_W'(cfg.min_separation));
    hit       = in_win && step_hit && sep_ok;
    count_new = hit ? sat_inc(count_r) : count_r;
  end

  always_comb begin
    prev_nxt      = prev_r;
    last_hit_nxt  = last_hit_r;
    hit_valid_nxt = hit_valid_r;
    count_nxt     = count_r;
    if (fire && in_range) begin
      if (last_sample) begin
        prev_nxt      = '0;
        last_hit_nxt  = '0;
        hit_valid_nxt = 1'b0;
        count_nxt     = '0;
      end else begin
        prev_nxt  = sample;
        count_nxt = count_new;
        if (hit) begin
          last_hit_nxt  = sample_index;
          hit_valid_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    wave_end.valid = fire && in_range && last_sample;
    wave_end.ch    = channel;
    wave_end.count = count_new;
    wave_end.eid   = evt_id;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      last_hit_r  <= '0;
      hit_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      prev_r      <= prev_nxt;
      last_hit_r  <= last_hit_nxt;
      hit_valid_r <= hit_valid_nxt;
      count_r     <= count_nxt;
    end
  end

endmodule

FILE: hdl/stcc_chan.sv
`timescale 1ns / 1ps

module stcc_chan #(
  parameter int NUM_CHANNELS = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  stcc_pkg::cfg_t      cfg,
  input  stcc_pkg::wave_end_t req,
  output logic                ready,
  output logic                res_valid,
  input  logic                res_ready,
  output stcc_pkg::result_t   res
);

  import stcc_pkg::*;

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [AW-1:0]           req_addr;
  logic [REC_W-1:0]        ram_q;

  logic                    s1_valid_r, s1_valid_nxt;
  logic [AW-1:0]           s1_ch_r, s1_ch_nxt;
  logic [CNT_W-1:0]        s1_count_r, s1_count_nxt;
  logic [EID_W-1:0]        s1_eid_r, s1_eid_nxt;
  logic                    rd_valid_r, rd_valid_nxt;

  logic [NUM_CHANNELS-1:0] entry_valid_r, entry_valid_nxt;

  logic                    fwd_valid_r, fwd_valid_nxt;
  logic [AW-1:0]           fwd_ch_r, fwd_ch_nxt;
  chan_rec_t               fwd_rec_r, fwd_rec_nxt;

  logic                    out_valid_r, out_valid_nxt;
  result_t                 out_r, out_nxt;

  logic                    s1_go;
  chan_rec_t               rec_old;
  chan_rec_t               rec_new;
  logic                    train;
  logic                    coinc;

  assign req_addr = AW'(req.ch);

  stcc_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_CHANNELS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_ch_r),
    .wdata (rec_new),
    .re    (req.valid),
    .raddr (req_addr),
    .rdata (ram_q)
  );

  always_comb begin
    s1_go = s1_valid_r && (!out_valid_r || res_ready);
    ready = !s1_valid_r || s1_go;
  end

  // The entry written on the previous commit may not yet be in the read data.
  always_comb begin
    if (fwd_valid_r && (fwd_ch_r == s1_ch_r)) begin
      rec_old = fwd_rec_r;
    end else if (rd_valid_r) begin
      rec_old = chan_rec_t'(ram_q);
    end else begin
      rec_old = '0;
    end

    train   = (s1_count_r >= cfg.train_min) && (s1_count_r <= cfg.train_max);
    coinc   = 1'b0;
    rec_new = rec_old;
    if (train) begin
      if ((rec_old.events_since != '0) && (rec_old.events_since <= cfg.coinc_distance)) begin
        coinc               = 1'b1;
        rec_new.coinc_total = sat_inc(rec_old.coinc_total);
        rec_new.last_id     = s1_eid_r;
        if (rec_old.first_id == '0) begin
          rec_new.first_id = s1_eid_r;
        end
      end
      rec_new.events_since = '0;
    end else begin
      rec_new.events_since = sat_inc(rec_old.events_since);
    end
  end

  always_comb begin
    s1_valid_nxt    = s1_valid_r;
    s1_ch_nxt       = s1_ch_r;
    s1_count_nxt    = s1_count_r;
    s1_eid_nxt      = s1_eid_r;
    rd_valid_nxt    = rd_valid_r;
    entry_valid_nxt = entry_valid_r;
    fwd_valid_nxt   = fwd_valid_r;
    fwd_ch_nxt      = fwd_ch_r;
    fwd_rec_nxt     = fwd_rec_r;
    out_valid_nxt   = out_valid_r;
    out_nxt         = out_r;

    if (res_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (s1_go) begin
      s1_valid_nxt             = 1'b0;
      entry_valid_nxt[s1_ch_r] = 1'b1;
      fwd_valid_nxt            = 1'b1;
      fwd_ch_nxt               = s1_ch_r;
      fwd_rec_nxt              = rec_new;
      out_valid_nxt            = 1'b1;
      out_nxt.ch               = CHAN_W'(s1_ch_r);
      out_nxt.spike_count      = s1_count_r;
      out_nxt.train_found      = train;
      out_nxt.coinc_found      = coinc;
      out_nxt.coinc_total      = rec_new.coinc_total;
      out_nxt.first_id         = rec_new.first_id;
      out_nxt.last_id          = rec_new.last_id;
    end

    if (req.valid) begin
      s1_valid_nxt = 1'b1;
      s1_ch_nxt    = req_addr;
      s1_count_nxt = req.count;
      s1_eid_nxt   = req.eid;
      rd_valid_nxt = entry_valid_r[req_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      entry_valid_r <= '0;
      fwd_valid_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      s1_valid_r    <= s1_valid_nxt;
      entry_valid_r <= entry_valid_nxt;
      fwd_valid_r   <= fwd_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_ch_r    <= s1_ch_nxt;
    s1_count_r <= s1_count_nxt;
    s1_eid_r   <= s1_eid_nxt;
    rd_valid_r <= rd_valid_nxt;
    fwd_ch_r   <= fwd_ch_nxt;
    fwd_rec_r  <= fwd_rec_nxt;
    out_r      <= out_nxt;
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

endmodule

FILE: hdl/spike_train_coincidence_counter.sv
`timescale 1ns / 1ps

// Counts spike steps in a sample window of each channel waveform and tracks trains and
// coincidences per channel. One sample transaction is taken every clock cycle unless the
// input stalls; the end of a waveform is registered in the channel stage, its result then
// in an output register, where it waits, so input flow stops only while that register and
// the channel stage are both full. The per-channel records live in one memory with a
// registered read, updated by a read-modify-write in the channel stage with forwarding of
// the latest write; per-entry valid bits cleared by reset stand in for zeroing it, so the
// block is ready straight after reset. Samples of a channel number at or above NUM_CHANNELS
// are dropped without effect.

module spike_train_coincidence_counter #(
  parameter int NUM_CHANNELS = stcc_pkg::NUM_CHANNELS_DEF,
  parameter int INDEX_BITS   = stcc_pkg::INDEX_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [stcc_pkg::CHAN_W-1:0]          in_channel,
  input  logic signed [stcc_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [INDEX_BITS-1:0]                in_sample_index,
  input  logic                                 in_last_sample,
  input  logic [stcc_pkg::EID_W-1:0]           in_event_id,

  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [stcc_pkg::CHAN_W-1:0]          out_channel,
  output logic [stcc_pkg::CNT_W-1:0]           out_spike_count,
  output logic                                 out_train_found,
  output logic                                 out_coincidence_found,
  output logic [stcc_pkg::CNT_W-1:0]           out_coincidence_total,
  output logic [stcc_pkg::EID_W-1:0]           out_first_coinc_event,
  output logic [stcc_pkg::EID_W-1:0]           out_last_coinc_event,

  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [stcc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [stcc_pkg::CFG_W-1:0]           cfg_data
);

  import stcc_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  logic      in_fire;
  wave_end_t wave_end;
  result_t   res;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_WINDOW_START:   cfg_nxt.window_start   = cfg_data;
        CFG_WINDOW_STOP:    cfg_nxt.window_stop    = cfg_data;
        CFG_STEP_THRESHOLD: cfg_nxt.step_threshold = cfg_data;
        CFG_MIN_SEPARATION: cfg_nxt.min_separation = cfg_data;
        CFG_TRAIN_MIN:      cfg_nxt.train_min      = cfg_data;
        CFG_TRAIN_MAX:      cfg_nxt.train_max      = cfg_data;
        CFG_COINC_DISTANCE: cfg_nxt.coinc_distance = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_start   <= RST_WINDOW_START;
      cfg_r.window_stop    <= RST_WINDOW_STOP;
      cfg_r.step_threshold <= RST_STEP_THRESHOLD;
      cfg_r.min_separation <= RST_MIN_SEPARATION;
      cfg_r.train_min      <= RST_TRAIN_MIN;
      cfg_r.train_max      <= RST_TRAIN_MAX;
      cfg_r.coinc_distance <= RST_COINC_DISTANCE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  stcc_wave #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .INDEX_BITS   (INDEX_BITS)
  ) u_wave (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .fire         (in_fire),
    .channel      (in_channel),
    .sample       (in_sample),
    .sample_index (in_sample_index),
    .last_sample  (in_last_sample),
    .evt_id       (in_event_id),
    .wave_end     (wave_end)
  );

  stcc_chan #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_chan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .req       (wave_end),
    .ready     (in_ready),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign out_channel           = res.ch;
  assign out_spike_count       = res.spike_count;
  assign out_train_found       = res.train_found;
  assign out_coincidence_found = res.coinc_found;
  assign out_coincidence_total = res.coinc_total;
  assign out_first_coinc_event = res.first_id;
  assign out_last_coinc_event  = res.last_id;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled while the output register was empty");

  a_channel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_channel) < NUM_CHANNELS))
    else $error("result transaction for a channel out of range");

  a_coinc_needs_train: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_coincidence_found) |->
      (out_train_found && (out_coincidence_total != '0)))
    else $error("coincidence reported without a train or a counted total");
`endif

endmodule

FILE: sim/spike_train_checker.sv
`timescale 1ns / 1ps

module spike_train_checker (
  input  logic                                    clk,
  input  logic                                    rst_n,

  input  logic                                    in_valid,
  input  logic                                    in_ready,
  input  logic [stcc_pkg::CHAN_W-1:0]             in_channel,
  input  logic signed [stcc_pkg::SAMPLE_W-1:0]    in_sample,
  input  logic [stcc_pkg::INDEX_BITS_DEF-1:0]     in_sample_index,
  input  logic                                    in_last_sample,
  input  logic [stcc_pkg::EID_W-1:0]              in_event_id,

  input  logic                                    out_valid,
  input  logic                                    out_ready,
  input  logic [stcc_pkg::CHAN_W-1:0]             out_channel,
  input  logic [stcc_pkg::CNT_W-1:0]              out_spike_count,
  input  logic                                    out_train_found,
  input  logic                                    out_coincidence_found,
  input  logic [stcc_pkg::CNT_W-1:0]              out_coincidence_total,
  input  logic [stcc_pkg::EID_W-1:0]              out_first_coinc_event,
  input  logic [stcc_pkg::EID_W-1:0]              out_last_coinc_event,

  input  logic                                    cfg_valid,
  input  logic                                    cfg_ready,
  input  logic [stcc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [stcc_pkg::CFG_W-1:0]              cfg_data,

  output int unsigned                             fail_count,
  output int unsigned                             reports_due
);

  import stcc_pkg::*;

  localparam int NCH = NUM_CHANNELS_DEF;

  cfg_t                          settings;
  logic signed [SAMPLE_W-1:0]    prev_sample;
  logic [INDEX_BITS_DEF-1:0]     last_hit;
  logic                          hit_seen;
  logic [CNT_W-1:0]              wave_spikes;
  logic [CNT_W-1:0]              since_train [NCH];
  logic [CNT_W-1:0]              coinc_tally [NCH];
  logic [EID_W-1:0]              first_ids   [NCH];
  logic [EID_W-1:0]              latest_ids  [NCH];
  result_t                       waveform_reports [$];
  int unsigned                   mismatches = 0;

  function automatic logic [CNT_W-1:0] saturating_bump(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  task automatic clear_waveform_state();
    prev_sample = '0;
    last_hit    = '0;
    hit_seen    = 1'b0;
    wave_spikes = '0;
  endtask

  task automatic apply_setting(input logic [CFG_IDX_W-1:0] which, input logic [CFG_W-1:0] value);
    case (which)
      CFG_WINDOW_START:   settings.window_start   = value;
      CFG_WINDOW_STOP:    settings.window_stop    = value;
      CFG_STEP_THRESHOLD: settings.step_threshold = value;
      CFG_MIN_SEPARATION: settings.min_separation = value;
      CFG_TRAIN_MIN:      settings.train_min      = value;
      CFG_TRAIN_MAX:      settings.train_max      = value;
      CFG_COINC_DISTANCE: settings.coinc_distance = value;
      default: ;
    endcase
  endtask

  task automatic tally_sample();
    int               now_idx, cur, prev, lo, hi, base, sep;
    logic [CHAN_W-1:0] ch;
    logic             train, coinc;
    result_t          rep;
    ch = in_channel;
    if (ch >= NCH) return;
    now_idx = int'(in_sample_index);
    cur     = int'(in_sample);
    prev    = int'(prev_sample);
    lo      = int'(settings.window_start);
    hi      = int'(settings.window_stop);
    if (now_idx > lo && now_idx <= hi) begin
      if (hit_seen) begin
        base = int'(last_hit);
      end else begin
        base = lo;
      end
      sep = now_idx - base;
      if (cur - prev > int'(settings.step_threshold) && sep >= int'(settings.min_separation)) begin
        wave_spikes = saturating_bump(wave_spikes);
        last_hit    = in_sample_index;
        hit_seen    = 1'b1;
      end
    end
    prev_sample = in_sample;
    if (!in_last_sample) return;

    train = wave_spikes >= settings.train_min && wave_spikes <= settings.train_max;
    coinc = 1'b0;
    if (train) begin
      if (since_train[ch] != 0 && since_train[ch] <= settings.coinc_distance) begin
        coinc           = 1'b1;
        coinc_tally[ch] = saturating_bump(coinc_tally[ch]);
        latest_ids[ch]  = in_event_id;
        if (first_ids[ch] == 0) first_ids[ch] = in_event_id;
      end
      since_train[ch] = '0;
    end else begin
      since_train[ch] = saturating_bump(since_train[ch]);
    end

    rep.ch          = ch;
    rep.spike_count = wave_spikes;
    rep.train_found = train;
    rep.coinc_found = coinc;
    rep.coinc_total = coinc_tally[ch];
    rep.first_id    = first_ids[ch];
    rep.last_id     = latest_ids[ch];
    waveform_reports = {waveform_reports, rep};
    clear_waveform_state();
  endtask

  task automatic check_field(input string what, input logic [EID_W-1:0] want, got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  task automatic compare_report();
    result_t want;
    if (waveform_reports.size() == 0) begin
      mismatches++;
      $display("%0t: result expected none, got channel %0d spike count %0d",
               $time, out_channel, out_spike_count);
    end else begin
      want = waveform_reports.pop_front();
      check_field("out_channel", want.ch, out_channel);
      check_field("out_spike_count", want.spike_count, out_spike_count);
      check_field("out_train_found", want.train_found, out_train_found);
      check_field("out_coincidence_found", want.coinc_found, out_coincidence_found);
      check_field("out_coincidence_total", want.coinc_total, out_coincidence_total);
      check_field("out_first_coinc_event", want.first_id, out_first_coinc_event);
      check_field("out_last_coinc_event", want.last_id, out_last_coinc_event);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      settings = {RST_WINDOW_START, RST_WINDOW_STOP, RST_STEP_THRESHOLD, RST_MIN_SEPARATION,
                  RST_TRAIN_MIN, RST_TRAIN_MAX, RST_COINC_DISTANCE};
      clear_waveform_state();
      for (int c = 0; c < NCH; c++) begin
        since_train[c] = '0;
        coinc_tally[c] = '0;
        first_ids[c]   = '0;
        latest_ids[c]  = '0;
      end
      waveform_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) apply_setting(cfg_index, cfg_data);
      if (out_valid && out_ready) compare_report();
      if (in_valid && in_ready) tally_sample();
    end
    fail_count  <= mismatches;
    reports_due <= waveform_reports.size();
  end

endmodule

FILE: sim/spike_train_coincidence_counter_test.sv
`timescale 1ns / 1ps

module spike_train_coincidence_counter_test;
  import stcc_pkg::*;

  localparam int                    NCH              = NUM_CHANNELS_DEF;
  localparam int unsigned           CYCLE_LIMIT      = 3_000_000;
  localparam int                    RX_HOLD_CYCLES   = 300;
  localparam int                    SETTLE_CYCLES    = 6;
  localparam int                    PHASE_ITEMS      = 140;
  localparam logic [CFG_IDX_W-1:0]  CFG_UNUSED_INDEX = 3'd7;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [CHAN_W-1:0]             in_channel;
  logic signed [SAMPLE_W-1:0]    in_sample;
  logic [INDEX_BITS_DEF-1:0]     in_sample_index;
  logic                          in_last_sample;
  logic [EID_W-1:0]              in_event_id;
  logic                          out_valid;
  logic                          out_ready;
  logic [CHAN_W-1:0]             out_channel;
  logic [CNT_W-1:0]              out_spike_count;
  logic                          out_train_found;
  logic                          out_coincidence_found;
  logic [CNT_W-1:0]              out_coincidence_total;
  logic [EID_W-1:0]              out_first_coinc_event;
  logic [EID_W-1:0]              out_last_coinc_event;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [CFG_W-1:0]              cfg_data;

  int unsigned fail_count;
  int unsigned reports_due;
  int unsigned cycle_count = 0;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic        hold_go;
  int          items_sent = 0;
  int          cur_ws = 0;
  int          cur_thr = 25;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  spike_train_coincidence_counter i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_channel            (in_channel),
    .in_sample             (in_sample),
    .in_sample_index       (in_sample_index),
    .in_last_sample        (in_last_sample),
    .in_event_id           (in_event_id),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_channel           (out_channel),
    .out_spike_count       (out_spike_count),
    .out_train_found       (out_train_found),
    .out_coincidence_found (out_coincidence_found),
    .out_coincidence_total (out_coincidence_total),
    .out_first_coinc_event (out_first_coinc_event),
    .out_last_coinc_event  (out_last_coinc_event),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  spike_train_checker i_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_channel            (in_channel),
    .in_sample             (in_sample),
    .in_sample_index       (in_sample_index),
    .in_last_sample        (in_last_sample),
    .in_event_id           (in_event_id),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_channel           (out_channel),
    .out_spike_count       (out_spike_count),
    .out_train_found       (out_train_found),
    .out_coincidence_found (out_coincidence_found),
    .out_coincidence_total (out_coincidence_total),
    .out_first_coinc_event (out_first_coinc_event),
    .out_last_coinc_event  (out_last_coinc_event),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .fail_count            (fail_count),
    .reports_due           (reports_due)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("spike_train_coincidence_counter_test: done, errors");
      $finish;
    end
  end

  // The receiver normally stalls at random; a toggle of hold_go starts one long hold-off.
  initial begin
    logic hold_seen;
    out_ready <= 1'b0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go !== hold_seen) begin
        hold_seen = hold_go;
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic signed [SAMPLE_W-1:0] s,
                             input logic [INDEX_BITS_DEF-1:0] idx, input logic last,
                             input logic [EID_W-1:0] eid);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_channel      <= ch;
    in_sample       <= s;
    in_sample_index <= idx;
    in_last_sample  <= last;
    in_event_id     <= eid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (ch < NCH) items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_setting(input logic [CFG_IDX_W-1:0] which, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic send_waveform(input logic [CHAN_W-1:0] ch, input int len);
    logic [EID_W-1:0] eid;
    int               idx, level, s, k;
    eid = ($urandom_range(0, 15) == 0) ? '0 : $urandom;
    idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : cur_ws - $urandom_range(0, 3);
    if (idx < 0) idx = 0;
    level = 0;
    for (k = 0; k < len; k++) begin
      if (k + 1 < len && $urandom_range(0, 29) == 0)
        send_sample(4'($urandom_range(0, 15)), 16'($urandom), 16'($urandom), 1'b0, $urandom);
      case ($urandom_range(0, 9))
        0:       s = $urandom_range(0, 65535) - 32768;
        1, 2, 3: s = level + cur_thr + $urandom_range(1, 40);
        default: s = $urandom_range(0, 40) - 20;
      endcase
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      send_sample(ch, 16'(s), 16'(idx), k + 1 == len, eid);
      level = s;
      if ($urandom_range(0, 24) == 0) begin
        idx -= $urandom_range(1, 20);
      end else begin
        idx += $urandom_range(0, 4);
      end
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] ws, we, thr, sep, tmin, tmax, cd,
                           input int quota, input bit squeeze);
    int target;
    drain();
    write_setting(CFG_WINDOW_START, ws);
    write_setting(CFG_WINDOW_STOP, we);
    write_setting(CFG_STEP_THRESHOLD, thr);
    write_setting(CFG_MIN_SEPARATION, sep);
    write_setting(CFG_TRAIN_MIN, tmin);
    write_setting(CFG_TRAIN_MAX, tmax);
    write_setting(CFG_COINC_DISTANCE, cd);
    write_setting(CFG_UNUSED_INDEX, 16'($urandom));
    cfg_valid <= 1'b0;
    cur_ws  = int'(ws);
    cur_thr = int'(thr);
    if (squeeze) hold_go <= ~hold_go;
    target = items_sent + quota;
    while (items_sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        send_sample(4'(NCH + $urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                    1'($urandom_range(0, 1)), $urandom);
      end else begin
        send_waveform(4'(($urandom_range(0, 4) == 0) ? $urandom_range(0, NCH - 1)
                                                      : $urandom_range(0, 3)),
                      ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 8));
      end
    end
  endtask

  initial begin
    int k;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_channel      <= '0;
    in_sample       <= '0;
    in_sample_index <= '0;
    in_last_sample  <= 1'b0;
    in_event_id     <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= CFG_WINDOW_START;
    cfg_data        <= '0;
    hold_go         <= 1'b0;
    send_idle_pct   <= 20;
    recv_idle_pct   <= 85;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset settings.
    send_sample(4'd0, -16'sd32768, 16'd0, 1'b0, 32'd1);
    send_sample(4'd0, 16'sd32767, 16'd100, 1'b0, 32'd1);
    send_sample(4'd0, 16'sd32767, 16'd150, 1'b0, 32'd1);
    send_sample(4'd0, -16'sd100, 16'd180, 1'b0, 32'd1);
    send_sample(4'd0, 16'sd200, 16'd199, 1'b0, 32'd1);
    send_sample(4'd0, -16'sd5, 16'd210, 1'b0, 32'd1);
    send_sample(4'd0, 16'sd500, 16'd50, 1'b0, 32'd1);
    send_sample(4'd14, 16'sd300, 16'd400, 1'b1, 32'd2);
    send_sample(4'd15, -16'sd300, 16'hffff, 1'b1, 32'hffff_ffff);
    send_sample(4'd0, 16'sd1000, 16'hffff, 1'b1, 32'hffff_ffff);
    send_sample(4'd0, 16'sd100, 16'd1000, 1'b1, 32'd0);
    send_sample(4'd0, 16'sd0, 16'd5, 1'b1, 32'd7);
    send_sample(4'd0, 16'sd50, 16'd500, 1'b1, 32'd0);
    send_sample(4'd0, 16'sd25, 16'd1000, 1'b1, 32'd3);
    send_sample(4'd0, 16'sd26, 16'd1000, 1'b1, 32'hffff_ffff);
    send_sample(4'd13, 16'sd26, 16'd1000, 1'b1, 32'd5);
    for (k = 0; k < 3; k++) send_sample(4'd13, 16'sd0, 16'd1000, 1'b1, 32'd6);
    send_sample(4'd13, 16'sd26, 16'd1000, 1'b1, 32'd8);

    run_phase(16'd0, 16'd40, 16'd20, 16'd3, 16'd1, 16'd4, 16'd3, PHASE_ITEMS, 1'b0);
    run_phase(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'd0,
              PHASE_ITEMS, 1'b0);
    send_idle_pct <= 85;
    recv_idle_pct <= 20;
    run_phase(16'd10, 16'd50, 16'd0, 16'd0, 16'd0, 16'hffff, 16'hffff, PHASE_ITEMS, 1'b0);
    run_phase(16'd30, 16'd0, 16'd10, 16'd1, 16'd0, 16'd0, 16'd2, PHASE_ITEMS, 1'b0);
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    run_phase(16'd0, 16'hffff, 16'd100, 16'd2, 16'd2, 16'd3, 16'd1, PHASE_ITEMS, 1'b1);
    run_phase(16'd5, 16'd30, 16'd15, 16'd4, 16'd1, 16'd2, 16'd5, PHASE_ITEMS, 1'b0);

    drain();
    if (fail_count == 0) begin
      $display("spike_train_coincidence_counter_test: done, clean");
    end else begin
      $display("spike_train_coincidence_counter_test: done, errors");
    end
    $finish;
  end

endmodule
